@@ src/pgns_pkg.sv @@
`timescale 1ns / 1ps

package pgns_pkg;

  // Default widths, handed to the top level parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int STATE_BITS_DEF  = 32;

  // Fixed formats
  localparam int CF         = 20;   // filter constants are Q.20
  localparam int NOTCH_SH   = 16;   // notch coefficients are Q8.16
  localparam int COEF_W     = 24;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_POLES  = 7;    // six poles plus the delayed term
  localparam int NUM_COEF   = 5;
  localparam int IDX_W      = 3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_NOTCH_A0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTCH_A1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTCH_A2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTCH_FB1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOTCH_FB2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTA_TH = 3'd5;

  // Register reset values
  localparam logic signed [COEF_W-1:0] RST_NOTCH_A0  = 24'sd2625897;
  localparam logic signed [COEF_W-1:0] RST_NOTCH_A1  = -24'sd5198580;
  localparam logic signed [COEF_W-1:0] RST_NOTCH_A2  = 24'sd2625897;
  localparam logic signed [COEF_W-1:0] RST_NOTCH_FB1 = 24'sd12974;
  localparam logic signed [COEF_W-1:0] RST_NOTCH_FB2 = -24'sd655;
  localparam logic [THR_W-1:0]         RST_QUANTA_TH = 16'd2163;

  // Fixed filter constants, round(c * 2^20)
  localparam logic signed [COEF_W-1:0] K_DIRECT   = 24'sd562246;
  localparam logic signed [COEF_W-1:0] K_DELAY    = 24'sd121557;
  localparam logic signed [COEF_W-1:0] K_PINK     = 24'sd188744;
  localparam logic signed [COEF_W-1:0] K_NOTCH_IN = 24'sd35652;
  localparam logic signed [COEF_W-1:0] K_GREY     = 24'sd120586;

  // Quanta codes
  localparam logic signed [1:0] QUANTA_ZERO = 2'sb00;
  localparam logic signed [1:0] QUANTA_POS  = 2'sb01;
  localparam logic signed [1:0] QUANTA_NEG  = 2'sb11;

  function automatic logic signed [COEF_W-1:0] pole_gain(input logic [IDX_W-1:0] i);
    logic signed [COEF_W-1:0] k;
    case (i)
      3'd0:    k = 24'sd1047381;
      3'd1:    k = 24'sd1041572;
      3'd2:    k = 24'sd1016070;
      3'd3:    k = 24'sd908591;
      3'd4:    k = 24'sd576717;
      3'd5:    k = -24'sd798595;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic signed [COEF_W-1:0] pole_in(input logic [IDX_W-1:0] i);
    logic signed [COEF_W-1:0] k;
    case (i)
      3'd0:    k = 24'sd58215;
      3'd1:    k = 24'sd78723;
      3'd2:    k = 24'sd161326;
      3'd3:    k = 24'sd325568;
      3'd4:    k = 24'sd558841;
      3'd5:    k = -24'sd17719;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  // Multiplier operand A
  typedef enum logic [2:0] {
    A_NONE,
    A_POLE,
    A_XS,
    A_Y,
    A_TAP,
    A_YSUM
  } a_sel_t;

  // Multiplier operand B
  typedef enum logic [3:0] {
    B_NONE,
    B_GAIN,
    B_IN,
    B_DIRECT,
    B_DELAY,
    B_NOTCH_IN,
    B_PINK,
    B_GREY,
    B_COEF
  } b_sel_t;

  // Accumulator operation on the registered product or on a pole register
  typedef enum logic [2:0] {
    AC_HOLD,
    AC_LOAD,
    AC_ADDP,
    AC_LOAD_R16,
    AC_ADD_R16,
    AC_LOAD_R20,
    AC_ADD_POLE
  } ac_op_t;

  // Write-back from the accumulator
  typedef enum logic [2:0] {
    WB_NONE,
    WB_POLE_R20,
    WB_POLE,
    WB_Y,
    WB_U,
    WB_YN,
    WB_PK,
    WB_GR
  } wb_op_t;

  typedef struct packed {
    a_sel_t           a_sel;
    b_sel_t           b_sel;
    logic [IDX_W-1:0] r_idx;
    ac_op_t           ac_op;
    wb_op_t           wb_op;
    logic [IDX_W-1:0] w_idx;
    logic             ld_in;
    logic             ld_out;
  } cmd_t;

  localparam cmd_t CMD_NOP = '{
    a_sel:  A_NONE,
    b_sel:  B_NONE,
    r_idx:  '0,
    ac_op:  AC_HOLD,
    wb_op:  WB_NONE,
    w_idx:  '0,
    ld_in:  1'b0,
    ld_out: 1'b0
  };

  localparam int                  STEP_W    = 6;
  localparam logic [STEP_W-1:0]   LAST_STEP = 6'd32;
  localparam int                  RESULT_LAT = 35;   // accept edge to out_valid seen

  // Microprogram. The product registered in step s is taken by the
  // accumulator in step s+1; write-back in step s sees the accumulator
  // as left by step s-1.
  function automatic cmd_t ucode(input logic [STEP_W-1:0] step);
    cmd_t c;
    c = CMD_NOP;
    unique case (step) inside
      [6'd0:6'd11]: begin
        // pole i: gain*pole then in*xs, interleaved with write-back
        c.r_idx = step[3:1];
        if (step[0]) begin
          c.a_sel = A_XS;
          c.b_sel = B_IN;
          c.ac_op = AC_LOAD;
          if (step != 6'd1) begin
            c.wb_op = WB_POLE_R20;
            c.w_idx = step[3:1] - 3'd1;
          end
        end else begin
          c.a_sel = A_POLE;
          c.b_sel = B_GAIN;
          if (step != 6'd0) begin
            c.ac_op = AC_ADDP;
          end
        end
      end
      6'd12: begin
        c.a_sel = A_XS;
        c.b_sel = B_DIRECT;
        c.ac_op = AC_ADDP;
      end
      6'd13: begin
        c.ac_op = AC_LOAD_R20;
        c.wb_op = WB_POLE_R20;
        c.w_idx = 3'd5;
      end
      [6'd14:6'd20]: begin
        // sum the new poles and the old delayed term
        c.ac_op = AC_ADD_POLE;
        c.r_idx = IDX_W'(step - 6'd14);
        if (step == 6'd20) begin
          c.a_sel = A_XS;
          c.b_sel = B_DELAY;
        end
      end
      6'd21: begin
        c.wb_op = WB_Y;
        c.ac_op = AC_LOAD_R20;
      end
      6'd22: begin
        c.wb_op = WB_POLE;
        c.w_idx = 3'd6;
        c.a_sel = A_Y;
        c.b_sel = B_NOTCH_IN;
      end
      6'd23: begin
        c.ac_op = AC_LOAD_R20;
        c.a_sel = A_TAP;
        c.b_sel = B_COEF;
        c.r_idx = 3'd1;
      end
      6'd24: begin
        c.wb_op = WB_U;
        c.ac_op = AC_LOAD_R16;
        c.a_sel = A_TAP;
        c.b_sel = B_COEF;
        c.r_idx = 3'd2;
      end
      6'd25: begin
        c.ac_op = AC_ADD_R16;
        c.a_sel = A_TAP;
        c.b_sel = B_COEF;
        c.r_idx = 3'd3;
      end
      6'd26: begin
        c.ac_op = AC_ADD_R16;
        c.a_sel = A_TAP;
        c.b_sel = B_COEF;
        c.r_idx = 3'd4;
      end
      6'd27: begin
        c.ac_op = AC_ADD_R16;
        c.a_sel = A_TAP;
        c.b_sel = B_COEF;
        c.r_idx = 3'd0;
      end
      6'd28: begin
        c.ac_op = AC_ADD_R16;
        c.a_sel = A_Y;
        c.b_sel = B_PINK;
      end
      6'd29: begin
        c.ac_op = AC_LOAD;
        c.wb_op = WB_YN;
      end
      6'd30: begin
        c.wb_op = WB_PK;
        c.a_sel = A_YSUM;
        c.b_sel = B_GREY;
      end
      6'd31: begin
        c.ac_op = AC_LOAD;
      end
      6'd32: begin
        c.wb_op = WB_GR;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

endpackage

@@ src/pgns_ctrl.sv @@
`timescale 1ns / 1ps

module pgns_ctrl import pgns_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              take;
  logic              ld_out;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_RUN;
          step_nxt  = '0;
        end
      end
      S_RUN: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_HOLD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = take ? S_RUN : S_IDLE;
          step_nxt  = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = CMD_NOP;
    in_stall = 1'b1;
    ld_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_RUN: begin
        cmd = ucode(step_r);
      end
      S_HOLD: begin
        in_stall = !out_free;
        ld_out   = out_free;
      end
      default: begin
      end
    endcase
    take       = in_valid && !in_stall;
    cmd.ld_in  = take;
    cmd.ld_out = ld_out;
  end

  assign out_valid_nxt = ld_out || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/pgns_datapath.sv @@
`timescale 1ns / 1ps

module pgns_datapath import pgns_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  input  logic signed [SAMPLE_BITS-1:0] white_sample,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic signed [SAMPLE_BITS-1:0] pink_out,
  output logic signed [SAMPLE_BITS-1:0] grey_out,
  output logic signed [1:0]             quanta_out
);

  localparam int SB      = SAMPLE_BITS;
  localparam int STB     = STATE_BITS;
  localparam int FRAC_B  = STB - 8;
  localparam int SF      = SB - 1;
  localparam int D       = FRAC_B - SF;
  localparam int A_W     = STB + 1;
  localparam int P_W     = A_W + COEF_W;
  localparam int ACC_W   = P_W + 4;
  localparam int OUT_SH  = CF + D;
  localparam int CMP_W   = SB + 16;

  localparam logic signed [ACC_W-1:0] ST_MAX = {{(ACC_W-STB+1){1'b0}}, {(STB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [ACC_W-1:0] SM_MAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SM_MIN = ~SM_MAX;

  function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] v,
                                                     input int unsigned s);
    logic signed [ACC_W-1:0] h;
    h = ACC_W'(1) <<< (s - 1);
    return (v + h) >>> s;
  endfunction

  function automatic logic signed [STB-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
    return c[STB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = (v > SM_MAX) ? SM_MAX : ((v < SM_MIN) ? SM_MIN : v);
    return c[SB-1:0];
  endfunction

  // ---- input conditioning ----
  logic signed [STB-1:0] xs_nxt, xs_r;

  if (D >= 0) begin : g_xs_up
    assign xs_nxt = STB'(white_sample) <<< D;
  end else begin : g_xs_down
    localparam int XS_SH = -D;
    logic signed [SB:0] xr;
    assign xr     = (SB+1)'(white_sample) + (SB+1)'(1 <<< (XS_SH - 1));
    assign xs_nxt = STB'(xr >>> XS_SH);
  end

  logic signed [SB:0]    xw;
  logic [SB:0]           mag;
  logic [CMP_W-1:0]      mag_sc, thr_sc;
  logic signed [1:0]     q_nxt, q_r;
  logic [THR_W-1:0]      thr_r;

  assign xw     = (SB+1)'(white_sample);
  assign mag    = xw[SB] ? unsigned'(-xw) : unsigned'(xw);
  assign mag_sc = {mag, 15'b0};
  assign thr_sc = {1'b0, thr_r, {SF{1'b0}}};

  always_comb begin
    if (xw == '0 || mag_sc > thr_sc) begin
      q_nxt = QUANTA_ZERO;
    end else begin
      q_nxt = xw[SB] ? QUANTA_NEG : QUANTA_POS;
    end
  end

  // ---- state and working registers ----
  logic signed [STB-1:0]    pole_r [NUM_POLES];
  logic signed [STB-1:0]    hist_r [4];          // u-1, u-2, yn-1, yn-2
  logic signed [COEF_W-1:0] coef_r [NUM_COEF];
  logic signed [STB-1:0]    u_r, y_r, yn_r;
  logic signed [SB-1:0]     pk_r, gr_r;
  logic signed [SB-1:0]     pink_r, grey_r;
  logic signed [1:0]        quanta_r;

  // ---- operand select ----
  logic signed [STB-1:0]    pole_rd, tap_rd;
  logic signed [COEF_W-1:0] coef_rd;
  logic signed [A_W-1:0]    a_op;
  logic signed [COEF_W-1:0] b_op;

  assign pole_rd = (cmd.r_idx < IDX_W'(NUM_POLES)) ? pole_r[cmd.r_idx] : '0;
  assign coef_rd = (cmd.r_idx < IDX_W'(NUM_COEF)) ? coef_r[cmd.r_idx] : '0;

  // tap index matches the coefficient index: u with a0, u-1 with a1, ...
  always_comb begin
    case (cmd.r_idx)
      3'd0:    tap_rd = u_r;
      3'd1:    tap_rd = hist_r[0];
      3'd2:    tap_rd = hist_r[1];
      3'd3:    tap_rd = hist_r[2];
      3'd4:    tap_rd = hist_r[3];
      default: tap_rd = '0;
    endcase
  end

  always_comb begin
    case (cmd.a_sel)
      A_POLE:  a_op = A_W'(pole_rd);
      A_XS:    a_op = A_W'(xs_r);
      A_Y:     a_op = A_W'(y_r);
      A_TAP:   a_op = A_W'(tap_rd);
      A_YSUM:  a_op = A_W'(y_r) + A_W'(yn_r);
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (cmd.b_sel)
      B_GAIN:     b_op = pole_gain(cmd.r_idx);
      B_IN:       b_op = pole_in(cmd.r_idx);
      B_DIRECT:   b_op = K_DIRECT;
      B_DELAY:    b_op = K_DELAY;
      B_NOTCH_IN: b_op = K_NOTCH_IN;
      B_PINK:     b_op = K_PINK;
      B_GREY:     b_op = K_GREY;
      B_COEF:     b_op = coef_rd;
      default:    b_op = '0;
    endcase
  end

  // ---- shared multiplier and accumulator ----
  logic signed [P_W-1:0]   p_nxt, p_r;
  logic signed [ACC_W-1:0] pe, acc_nxt, acc_r;
  logic signed [ACC_W-1:0] acc_r20, acc_ro;

  assign p_nxt = a_op * b_op;
  assign pe    = ACC_W'(p_r);

  always_comb begin
    case (cmd.ac_op)
      AC_LOAD:     acc_nxt = pe;
      AC_ADDP:     acc_nxt = acc_r + pe;
      AC_LOAD_R16: acc_nxt = rnd_sh(pe, NOTCH_SH);
      AC_ADD_R16:  acc_nxt = acc_r + rnd_sh(pe, NOTCH_SH);
      AC_LOAD_R20: acc_nxt = rnd_sh(pe, CF);
      AC_ADD_POLE: acc_nxt = acc_r + ACC_W'(pole_rd);
      default:     acc_nxt = acc_r;
    endcase
  end

  assign acc_r20 = rnd_sh(acc_r, CF);
  assign acc_ro  = rnd_sh(acc_r, OUT_SH);

  // filter state and registers, cleared or preset by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POLES; i++) begin
        pole_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        hist_r[i] <= '0;
      end
      coef_r[0] <= RST_NOTCH_A0;
      coef_r[1] <= RST_NOTCH_A1;
      coef_r[2] <= RST_NOTCH_A2;
      coef_r[3] <= RST_NOTCH_FB1;
      coef_r[4] <= RST_NOTCH_FB2;
      thr_r     <= RST_QUANTA_TH;
    end else begin
      case (cmd.wb_op)
        WB_POLE_R20: pole_r[cmd.w_idx] <= sat_st(acc_r20);
        WB_POLE:     pole_r[cmd.w_idx] <= sat_st(acc_r);
        WB_YN: begin
          hist_r[1] <= hist_r[0];
          hist_r[0] <= u_r;
          hist_r[3] <= hist_r[2];
          hist_r[2] <= sat_st(acc_r);
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        unique case (cfg_index) inside
          REG_NOTCH_A0, REG_NOTCH_A1, REG_NOTCH_A2, REG_NOTCH_FB1, REG_NOTCH_FB2:
            coef_r[cfg_index] <= cfg_data;
          REG_QUANTA_TH: thr_r <= cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // working and output registers
  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
    if (cmd.ld_in) begin
      xs_r <= xs_nxt;
      q_r  <= q_nxt;
    end
    case (cmd.wb_op)
      WB_Y:    y_r  <= sat_st(acc_r);
      WB_U:    u_r  <= sat_st(acc_r);
      WB_YN:   yn_r <= sat_st(acc_r);
      WB_PK:   pk_r <= sat_smp(acc_ro);
      WB_GR:   gr_r <= sat_smp(acc_ro);
      default: begin
      end
    endcase
    if (cmd.ld_out) begin
      pink_r   <= pk_r;
      grey_r   <= gr_r;
      quanta_r <= q_r;
    end
  end

  assign pink_out   = pink_r;
  assign grey_out   = grey_r;
  assign quanta_out = quanta_r;

endmodule

@@ src/pink_grey_noise_shaper.sv @@
`timescale 1ns / 1ps

// Pink / grey noise shaper.
// Input channel (in_valid / in_stall / in_white_sample): one white sample
// per word, Q1.15 at the default width. Output channel (out_valid / out_stall)
// carries pink_out, grey_out (Q1.15, saturated) and quanta_out (-1/0/+1).
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): notch a0, a1,
// a2, fb1, fb2 (Q8.16) and the quanta threshold; cfg_ready is always high,
// write only while the block is idle.
// Timing: one multiplier is shared by all 22 products of a sample, driven by
// a 33-step microprogram; the result is loaded into the output register with
// out_valid at the end of a run, and a new word is taken only after that run.
// The input is taken again while the previous result waits in the output
// register; only when that register is still occupied at the end of a run
// does the block hold, with in_stall high, until the receiver drops out_stall.
// Reset clears the filter state, presets the registers to the default notch
// and threshold, and leaves out_valid low.
module pink_grey_noise_shaper import pgns_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_white_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_pink_out,
  output logic signed [SAMPLE_BITS-1:0] out_grey_out,
  output logic signed [1:0]             out_quanta_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cmd_t cmd;
  logic cfg_we;
  logic in_take;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_take   = in_valid && !in_stall;

  // sequencer: accepts words, steps the microprogram, owns out_valid
  pgns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // filter state, shared MAC and output register
  pgns_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .white_sample (in_white_sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pink_out     (out_pink_out),
    .grey_out     (out_grey_out),
    .quanta_out   (out_quanta_out)
  );

  // one word at a time: busy straight after taking a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input taken while a sample is in flight");

  // a result is on offer by the end of the run
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##RESULT_LAT out_valid)
    else $error("no result after the run");

  // quanta code is -1, 0 or +1
  a_quanta_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quanta_out == QUANTA_ZERO) || (out_quanta_out == QUANTA_POS)
                  || (out_quanta_out == QUANTA_NEG))
    else $error("bad quanta code");

endmodule

@@ dv/pgns_checker.sv @@
`timescale 1ns / 1ps

// Watches the three channels of the noise shaper, keeps its own copy of the
// filter state and registers, and scores every output word in order.
module pgns_checker import pgns_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [SAMPLE_BITS_DEF-1:0] in_white_sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [SAMPLE_BITS_DEF-1:0] out_pink_out,
  input  logic signed [SAMPLE_BITS_DEF-1:0] out_grey_out,
  input  logic signed [1:0]                 out_quanta_out,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  output int                                fail_count,
  output int                                words_checked
);

  localparam int SW        = SAMPLE_BITS_DEF;
  localparam int PW        = STATE_BITS_DEF;
  localparam int TO_STATE  = (PW - 8) - (SW - 1);   // sample to state alignment
  localparam int OUT_SHIFT = CF + TO_STATE;
  localparam int MAX_SHOWN = 10;

  // Kellet pole feedback and input gains, Q.20, element 0 last
  localparam logic [5:0][23:0] POLE_FB = {
    -24'sd798595, 24'sd576717, 24'sd908591, 24'sd1016070, 24'sd1041572, 24'sd1047381
  };
  localparam logic [5:0][23:0] POLE_FF = {
    -24'sd17719, 24'sd558841, 24'sd325568, 24'sd161326, 24'sd78723, 24'sd58215
  };
  localparam longint DIRECT_GAIN = 562246;
  localparam longint DELAY_GAIN  = 121557;
  localparam longint PINK_SCALE  = 188744;
  localparam longint NOTCH_FEED  = 35652;
  localparam longint GREY_SCALE  = 120586;

  typedef struct packed {
    logic signed [SW-1:0] white;
    logic signed [SW-1:0] pink;
    logic signed [SW-1:0] grey;
    logic signed [1:0]    quanta;
  } shaped_word_t;

  shaped_word_t shaped_q[$];

  longint pole_acc [7];
  longint notch_tap [4];   // u-1, u-2, yn-1, yn-2
  longint a0, a1, a2, fb1, fb2;
  longint quanta_thr;
  int     errs;
  int     seen;

  function automatic longint round_sr(input longint p, input int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // Advances the filter state by one white sample and returns the outputs
  function automatic shaped_word_t shape_sample(input logic signed [SW-1:0] white);
    shaped_word_t r;
    longint x, xs, acc, y, u, yn, mag, g, f;
    x  = white;
    xs = x <<< TO_STATE;
    for (int i = 0; i < 6; i++) begin
      g = $signed(POLE_FB[i]);
      f = $signed(POLE_FF[i]);
      pole_acc[i] = clamp(round_sr(g * pole_acc[i] + f * xs, CF), PW);
    end
    acc = round_sr(DIRECT_GAIN * xs, CF);
    for (int i = 0; i < 7; i++) acc += pole_acc[i];   // old delayed term
    y = clamp(acc, PW);
    pole_acc[6] = clamp(round_sr(DELAY_GAIN * xs, CF), PW);

    u   = clamp(round_sr(y * NOTCH_FEED, CF), PW);
    acc = round_sr(a0 * u, NOTCH_SH) + round_sr(a1 * notch_tap[0], NOTCH_SH)
        + round_sr(a2 * notch_tap[1], NOTCH_SH) + round_sr(fb1 * notch_tap[2], NOTCH_SH)
        + round_sr(fb2 * notch_tap[3], NOTCH_SH);
    yn = clamp(acc, PW);
    notch_tap[1] = notch_tap[0];
    notch_tap[0] = u;
    notch_tap[3] = notch_tap[2];
    notch_tap[2] = yn;

    r.white = white;
    r.pink  = clamp(round_sr(y * PINK_SCALE, OUT_SHIFT), SW);
    r.grey  = clamp(round_sr((y + yn) * GREY_SCALE, OUT_SHIFT), SW);
    mag = x < 0 ? -x : x;
    if (x != 0 && mag <= quanta_thr) begin
      r.quanta = x > 0 ? QUANTA_POS : QUANTA_NEG;
    end else begin
      r.quanta = QUANTA_ZERO;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    shaped_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) pole_acc[i] = 0;
      for (int i = 0; i < 4; i++) notch_tap[i] = 0;
      a0 = RST_NOTCH_A0;
      a1 = RST_NOTCH_A1;
      a2 = RST_NOTCH_A2;
      fb1 = RST_NOTCH_FB1;
      fb2 = RST_NOTCH_FB2;
      quanta_thr = RST_QUANTA_TH;
      shaped_q.delete();
      errs = 0;
      seen = 0;
    end else begin
      // results first: a word taken this edge cannot already be out
      if (out_valid && !out_stall) begin
        seen++;
        if (shaped_q.size() == 0) begin
          errs++;
          if (errs <= MAX_SHOWN) begin
            $display("[%0t] unexpected output word: pink %0d grey %0d quanta %0d",
                     $realtime, out_pink_out, out_grey_out, out_quanta_out);
          end
        end else begin
          want = shaped_q.pop_front();
          if (out_pink_out !== want.pink || out_grey_out !== want.grey ||
              out_quanta_out !== want.quanta) begin
            errs++;
            if (errs <= MAX_SHOWN) begin
              $display("[%0t] word %0d (white %0d): pink exp %0d got %0d, grey exp %0d got %0d, quanta exp %0d got %0d",
                       $realtime, seen, want.white, want.pink, out_pink_out,
                       want.grey, out_grey_out, want.quanta, out_quanta_out);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NOTCH_A0:  a0 = $signed(cfg_data);
          REG_NOTCH_A1:  a1 = $signed(cfg_data);
          REG_NOTCH_A2:  a2 = $signed(cfg_data);
          REG_NOTCH_FB1: fb1 = $signed(cfg_data);
          REG_NOTCH_FB2: fb2 = $signed(cfg_data);
          REG_QUANTA_TH: quanta_thr = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) shaped_q.push_back(shape_sample(in_white_sample));
    end
    fail_count    <= errs;
    words_checked <= seen;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the pink / grey noise shaper. Scoring lives in
// pgns_checker, which sits beside the DUT on the same wires.
module tb_top;
  import pgns_pkg::*;

  localparam int SW              = SAMPLE_BITS_DEF;
  localparam int NUM_PHASES      = 8;
  localparam int WORDS_PER_PHASE = 210;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RESET_CYCLES    = 10;

  // Indexes outside the register map; writes there must be harmless
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [CFG_DATA_W-1:0] COEF_MAX = 24'h7FFFFF;
  localparam logic [CFG_DATA_W-1:0] COEF_MIN = 24'h800000;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic signed [SW-1:0] in_white_sample = '0;
  logic                 out_stall       = 1'b0;
  logic                 cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic signed [SW-1:0] out_pink_out;
  logic signed [SW-1:0] out_grey_out;
  logic signed [1:0]    out_quanta_out;
  logic                 cfg_ready;

  int fail_count;
  int words_checked;

  // Idle mix, percent of cycles, changed per phase
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int samples_sent       = 0;
  int cycles             = 0;

  pink_grey_noise_shaper DUT (.*);

  pgns_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random back-pressure at the rate the current phase asks
  always @(posedge clk) begin
    out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  // Hard stop in case the block locks up
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pink_grey_noise_shaper: mismatch");
    $finish;
  end

  // One white sample per word. Valid is only dropped for a sender gap or at
  // the end of a burst of words, never between two back-to-back words.
  task automatic send_white(input logic signed [SW-1:0] w);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_white_sample <= w;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Pause the sender until every outstanding word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (words_checked < samples_sent) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic signed [SW-1:0]  fixed_words [11];
    logic [CFG_DATA_W-1:0] coef [5];
    logic [THR_W-1:0]      thr;
    logic signed [SW-1:0]  burst_level;
    logic signed [SW-1:0]  white;
    int                    burst_left;
    int                    thr_now;
    int                    roll;
    int                    mag;

    fixed_words = '{16'sd0, 16'sd1, -16'sd1, 16'sd2163, -16'sd2163, 16'sd2164,
                    -16'sd2164, 16'sd32767, -16'sd32768, 16'sh5555, 16'shAAAA};
    burst_left  = 0;
    burst_level = '0;
    thr_now     = RST_QUANTA_TH;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers, zero, unit steps, the default threshold
    // edges, both rails, alternating bit patterns, then a run at each rail
    // to push the pink and grey outputs into saturation.
    foreach (fixed_words[i]) send_white(fixed_words[i]);
    repeat (7) send_white(16'sh7FFF);
    repeat (7) send_white(16'sh8000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // registers only change with the pipeline empty
      drain();

      case (p)
        0: begin   // back to the defaults, this time by explicit write
          coef = '{RST_NOTCH_A0, RST_NOTCH_A1, RST_NOTCH_A2, RST_NOTCH_FB1, RST_NOTCH_FB2};
          thr  = RST_QUANTA_TH;
        end
        1: begin   // everything at the top; threshold above one lets every nonzero sample pass
          coef = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
          thr  = 16'hFFFF;
        end
        2: begin   // everything at the bottom, no quanta at all
          coef = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN};
          thr  = '0;
        end
        3: begin   // alternating rails; threshold of exactly one
          coef = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
          thr  = 16'h8000;
        end
        default: begin
          // half full-scale, half close to a sane notch so the
          // feedback path does not just sit on its rail
          foreach (coef[i]) begin
            if ($urandom_range(1) == 1) begin
              coef[i] = CFG_DATA_W'($urandom);
            end else begin
              coef[i] = CFG_DATA_W'(int'($urandom_range(262143)) - 131072);
            end
          end
          thr = THR_W'($urandom_range(65535));
        end
      endcase
      thr_now = thr;

      write_reg(REG_NOTCH_A0,  coef[0]);
      write_reg(REG_NOTCH_A1,  coef[1]);
      write_reg(REG_NOTCH_A2,  coef[2]);
      write_reg(REG_NOTCH_FB1, coef[3]);
      write_reg(REG_NOTCH_FB2, coef[4]);
      // upper data bits are don't-care for the threshold
      write_reg(REG_QUANTA_TH, {8'($urandom), thr});
      if (p == 5) begin
        write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
      end
      cfg_valid <= 1'b0;

      // idle mix: none, sender gaps, receiver stalls, light on both
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (burst_left != 0) begin
          // sustained same-sign drive; XOR on the low byte keeps the sign
          burst_left--;
          white = burst_level ^ SW'($urandom_range(255));
        end else begin
          roll = $urandom_range(99);
          if (roll < 45) begin
            white = SW'($urandom);
          end else if (roll < 65) begin
            // small samples, where quanta pulses live
            mag   = $urandom_range(4400);
            white = ($urandom_range(1) == 1) ? SW'(-mag) : SW'(mag);
          end else if (roll < 75) begin
            case ($urandom_range(4))
              0: white = 16'sd0;
              1: white = 16'sd1;
              2: white = -16'sd1;
              3: white = 16'sh7FFF;
              default: white = 16'sh8000;
            endcase
          end else if (roll < 85) begin
            burst_left = $urandom_range(120, 20);
            case ($urandom_range(2))
              0: burst_level = 16'sh7FFF;
              1: burst_level = 16'sh8000;
              default: burst_level = SW'($urandom);
            endcase
            white = burst_level;
          end else begin
            // straddle the current threshold
            mag = thr_now + int'($urandom_range(2)) - 1;
            if (mag < 0) mag = 0;
            if ($urandom_range(1) == 1) begin
              if (mag > 32768) mag = 32768;
              white = SW'(-mag);
            end else begin
              if (mag > 32767) mag = 32767;
              white = SW'(mag);
            end
          end
        end
        send_white(white);
      end
    end

    in_valid <= 1'b0;
    while (words_checked < samples_sent) @(posedge clk);
    repeat (RESULT_LAT + 4) @(posedge clk);

    $display("Covered %0d white samples (%0d output words scored) over %0d register settings",
             samples_sent, words_checked, NUM_PHASES + 1);
    $display("with rail bursts, threshold edges and four sender/receiver idle mixes.");
    if (fail_count == 0 && words_checked == samples_sent) begin
      $display("pink_grey_noise_shaper: match");
    end else begin
      $display("pink_grey_noise_shaper: mismatch");
    end
    $finish;
  end

endmodule
